// File: src/pbd_pkg.sv
// Shared types, constants and decode helpers for the bank port decoder.
// No dependencies; used by every module of the block.
package pbd_pkg;

    localparam logic OP_PORT_WRITE = 1'b0;
    localparam logic OP_CPU_WRITE  = 1'b1;

    localparam logic [2:0] MM_NONE    = 3'd0;
    localparam logic [2:0] MM_128K    = 3'd1;
    localparam logic [2:0] MM_256K    = 3'd2;
    localparam logic [2:0] MM_320K    = 3'd3;
    localparam logic [2:0] MM_320K_A  = 3'd4;
    localparam logic [2:0] MM_576K    = 3'd5;
    localparam logic [2:0] MM_576K_A  = 3'd6;
    localparam logic [2:0] MM_1088K   = 3'd7;

    localparam logic [2:0] HW_800     = 3'd0;
    localparam logic [2:0] HW_800XL   = 3'd1;
    localparam logic [2:0] HW_1200XL  = 3'd2;
    localparam logic [2:0] HW_XEGS    = 3'd3;
    localparam logic [2:0] HW_130XE   = 3'd4;

    localparam logic [2:0] REG_MEMORY_MODE  = 3'd0;
    localparam logic [2:0] REG_HW_MODE      = 3'd1;
    localparam logic [2:0] REG_FORCE_BASIC  = 3'd2;
    localparam logic [2:0] REG_SELF_TEST    = 3'd3;
    localparam logic [2:0] REG_HIDDEN_RAM   = 3'd4;
    localparam logic [2:0] REG_ADDON_BITS   = 3'd5;
    localparam logic [2:0] REG_ADDON_ALIAS  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    localparam logic [7:0]  PORT_RESET     = 8'hFF;
    localparam logic [15:0] HIGH_CTL_BASE  = 16'hCFF0;
    localparam logic [15:0] HIGH_CTL_LAST  = 16'hCFFF;
    localparam logic [15:0] LOW_CTL_BASE   = 16'h0FF0;
    localparam logic [15:0] LOW_CTL_LAST   = 16'h0FFF;

    typedef struct packed {
        logic [2:0] memory_mode;
        logic [2:0] hardware_mode;
        logic       force_basic;
        logic       self_test_present;
        logic       hidden_ram_present;
        logic [3:0] addon_bank_bits;
        logic       addon_aliasing;
    } cfg_t;

    typedef struct packed {
        logic       kernel_enabled;
        logic       basic_enabled;
        logic       self_test_enabled;
        logic       game_enabled;
        logic       hidden_ram_enabled;
        logic       cpu_window_extended;
        logic       video_window_extended;
        logic       port_bank_active;
        logic [6:0] ext_bank;
        logic [7:0] addon_bank;
    } result_t;

    function automatic logic [7:0] addon_mask(input logic [3:0] bits);
        logic [7:0] m;
        if (bits >= 4'd8)
            m = 8'hFF;
        else
            m = (8'd1 << bits[2:0]) - 8'd1;
        return m;
    endfunction

    // kernel ROM forced on for models without a switchable kernel
    function automatic logic kernel_on(input logic [2:0] hw, input logic [7:0] p);
        logic kmask;
        kmask = !(hw == HW_800XL || hw == HW_1200XL || hw == HW_XEGS || hw == HW_130XE);
        return p[0] | kmask;
    endfunction

endpackage

// File: src/portb_bank_decoder.sv
// Bank port decoder: maps port byte and add-on card bank to ROM/window controls.
// Top level; instantiates pbd_state, pbd_decode and pbd_out, uses pbd_pkg.
//
// Input channel (in_valid/in_stall): op 0 writes the bank port byte, op 1 is a
// CPU write that may hit an add-on card control mirror. One beat in gives one
// result beat out on out_valid/out_stall with every decoded control field.
// Throughput is one beat per cycle while the skid entry is free; the decode is a
// single combinational pass between the state registers and the result register.
// A one-entry skid stage lets one more beat in while a result is stalled; the
// input stalls only when that skid entry is full.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the user
// must write only while no beat is in flight; the block does not enforce this.
// Reset: port byte reads 0xFF, add-on bank 0, self-test present, other
// settings 0; no result is pending.
module portb_bank_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [15:0]                     address,
    input  logic [7:0]                      value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kernel_enabled,
    output logic                            basic_enabled,
    output logic                            self_test_enabled,
    output logic                            game_enabled,
    output logic                            hidden_ram_enabled,
    output logic                            cpu_window_extended,
    output logic                            video_window_extended,
    output logic                            port_bank_active,
    output logic [6:0]                      ext_bank,
    output logic [7:0]                      addon_bank
);

    pbd_pkg::cfg_t    cfg;
    pbd_pkg::result_t dec_res;
    pbd_pkg::result_t out_res;
    logic [7:0]       port_byte_next;
    logic [7:0]       addon_bank_next;
    logic             accept;

    assign accept = in_valid && !in_stall;

    pbd_state u_state (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .op              (op),
        .address         (address),
        .value           (value),
        .cfg             (cfg),
        .port_byte_next  (port_byte_next),
        .addon_bank_next (addon_bank_next)
    );

    pbd_decode u_decode (
        .cfg        (cfg),
        .port_byte  (port_byte_next),
        .addon_bank (addon_bank_next),
        .res        (dec_res)
    );

    pbd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_res  (dec_res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kernel_enabled        = out_res.kernel_enabled;
    assign basic_enabled         = out_res.basic_enabled;
    assign self_test_enabled     = out_res.self_test_enabled;
    assign game_enabled          = out_res.game_enabled;
    assign hidden_ram_enabled    = out_res.hidden_ram_enabled;
    assign cpu_window_extended   = out_res.cpu_window_extended;
    assign video_window_extended = out_res.video_window_extended;
    assign port_bank_active      = out_res.port_bank_active;
    assign ext_bank              = out_res.ext_bank;
    assign addon_bank            = out_res.addon_bank;

endmodule

// File: src/pbd_state.sv
// Configuration registers, bank port byte and add-on bank register.
// Depends on pbd_pkg; drives next state to pbd_decode.
module pbd_state (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                          accept,
    input  logic                          op,
    input  logic [15:0]                   address,
    input  logic [7:0]                    value,
    output pbd_pkg::cfg_t                 cfg,
    output logic [7:0]                    port_byte_next,
    output logic [7:0]                    addon_bank_next
);

    pbd_pkg::cfg_t cfg_reg;
    pbd_pkg::cfg_t cfg_next;
    logic [7:0]    port_byte_reg;
    logic [7:0]    addon_bank_reg;
    logic [7:0]    mask;
    logic          high_hit;
    logic          low_hit;
    logic          ctl_hit;

    assign mask = pbd_pkg::addon_mask(cfg_reg.addon_bank_bits);

    always_comb
    begin
        high_hit = pbd_pkg::kernel_on(cfg_reg.hardware_mode, port_byte_reg) &&
                   address >= pbd_pkg::HIGH_CTL_BASE && address <= pbd_pkg::HIGH_CTL_LAST;
        low_hit  = cfg_reg.addon_aliasing && cfg_reg.hardware_mode == pbd_pkg::HW_800 &&
                   address >= pbd_pkg::LOW_CTL_BASE && address <= pbd_pkg::LOW_CTL_LAST;
        ctl_hit  = op == pbd_pkg::OP_CPU_WRITE && cfg_reg.addon_bank_bits != 4'd0 &&
                   (high_hit || low_hit);

        port_byte_next  = port_byte_reg;
        addon_bank_next = addon_bank_reg;
        if (accept && op == pbd_pkg::OP_PORT_WRITE)
            port_byte_next = value;
        if (accept && ctl_hit)
            addon_bank_next = value & mask;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pbd_pkg::REG_MEMORY_MODE: cfg_next.memory_mode        = cfg_data[2:0];
                pbd_pkg::REG_HW_MODE:     cfg_next.hardware_mode      = cfg_data[2:0];
                pbd_pkg::REG_FORCE_BASIC: cfg_next.force_basic        = cfg_data[0];
                pbd_pkg::REG_SELF_TEST:   cfg_next.self_test_present  = cfg_data[0];
                pbd_pkg::REG_HIDDEN_RAM:  cfg_next.hidden_ram_present = cfg_data[0];
                pbd_pkg::REG_ADDON_BITS:  cfg_next.addon_bank_bits    = cfg_data;
                pbd_pkg::REG_ADDON_ALIAS: cfg_next.addon_aliasing     = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '{memory_mode: pbd_pkg::MM_NONE, hardware_mode: pbd_pkg::HW_800,
                                force_basic: 1'b0, self_test_present: 1'b1,
                                hidden_ram_present: 1'b0, addon_bank_bits: 4'd0,
                                addon_aliasing: 1'b0};
            port_byte_reg  <= pbd_pkg::PORT_RESET;
            addon_bank_reg <= 8'd0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            port_byte_reg <= port_byte_next;
            // user writes config only while idle, unchecked; mask bank to new width
            if (cfg_we && cfg_index == pbd_pkg::REG_ADDON_BITS)
                addon_bank_reg <= addon_bank_reg & pbd_pkg::addon_mask(cfg_data);
            else
                addon_bank_reg <= addon_bank_next;
        end
    end

    assign cfg = cfg_reg;

`ifndef NO_ASSERTIONS
    a_bank_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (addon_bank_reg & ~mask) == 8'd0)
        else $error("add-on bank holds bits beyond configured width");
    a_port_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(port_byte_reg))
        else $error("port byte changed without a beat");
`endif

endmodule

// File: src/pbd_decode.sv
// Combinational decode of port byte and add-on bank into the mapping result.
// Depends on pbd_pkg.
module pbd_decode (
    input  pbd_pkg::cfg_t    cfg,
    input  logic [7:0]       port_byte,
    input  logic [7:0]       addon_bank,
    output pbd_pkg::result_t res
);

    logic [2:0] mm;
    logic [2:0] hw;
    logic [5:0] extmask;
    logic       cpubit;
    logic       vidbit_hi;
    logic       vidbit_lo;
    logic [6:0] offset;
    logic       block_basic;
    logic       bmask;
    logic       xcpu;
    logic       xvid;
    logic       ext;
    logic [5:0] b;
    logic       basic;
    logic       st_blocked;

    assign mm = cfg.memory_mode;
    assign hw = cfg.hardware_mode;

    always_comb
    begin
        case (mm)
            pbd_pkg::MM_128K:                                        extmask = 6'h03;
            pbd_pkg::MM_256K, pbd_pkg::MM_320K, pbd_pkg::MM_320K_A:  extmask = 6'h0F;
            pbd_pkg::MM_576K, pbd_pkg::MM_576K_A:                    extmask = 6'h1F;
            pbd_pkg::MM_1088K:                                       extmask = 6'h3F;
            default:                                                 extmask = 6'h00;
        endcase
        case (mm)
            pbd_pkg::MM_256K:                                        offset = 7'h00;
            pbd_pkg::MM_128K, pbd_pkg::MM_320K, pbd_pkg::MM_320K_A:  offset = 7'h14;
            default:                                                 offset = 7'h04;
        endcase

        cpubit      = extmask != 6'h00;
        vidbit_hi   = mm == pbd_pkg::MM_128K || mm == pbd_pkg::MM_320K_A ||
                      mm == pbd_pkg::MM_576K_A;
        vidbit_lo   = mm == pbd_pkg::MM_256K || mm == pbd_pkg::MM_320K ||
                      mm == pbd_pkg::MM_576K || mm == pbd_pkg::MM_1088K;
        block_basic = mm == pbd_pkg::MM_576K || mm == pbd_pkg::MM_576K_A ||
                      mm == pbd_pkg::MM_1088K;

        bmask = !cfg.force_basic;
        if (hw == pbd_pkg::HW_800XL || hw == pbd_pkg::HW_XEGS || hw == pbd_pkg::HW_130XE)
            bmask = 1'b0;

        xcpu = cpubit && !port_byte[4];
        xvid = (vidbit_hi && !port_byte[5]) || (vidbit_lo && !port_byte[4]);
        ext  = xcpu || xvid;

        // bank bits never overlap, so the sums reduce to field packing
        if (mm == pbd_pkg::MM_256K)
            b = {2'b00, port_byte[6:5], port_byte[3:2]};
        else if (mm == pbd_pkg::MM_320K_A || mm == pbd_pkg::MM_576K_A)
            b = {1'b0, !port_byte[1], ~port_byte[7:6], ~port_byte[3:2]};
        else
            b = {!port_byte[7], !port_byte[1], ~port_byte[6:5], ~port_byte[3:2]};

        st_blocked = (mm == pbd_pkg::MM_320K_A || mm == pbd_pkg::MM_576K_A ||
                      mm == pbd_pkg::MM_1088K) && ext;
        basic      = !(port_byte[1] | bmask) && (!block_basic || !ext);

        res.kernel_enabled        = pbd_pkg::kernel_on(hw, port_byte);
        res.basic_enabled         = basic;
        res.self_test_enabled     = cfg.self_test_present && port_byte[0] && !port_byte[7] &&
                                    !st_blocked;
        res.game_enabled          = hw == pbd_pkg::HW_XEGS && !basic && !port_byte[6];
        res.hidden_ram_enabled    = cfg.hidden_ram_present && !port_byte[7] &&
                                    port_byte[5] && port_byte[4] && !port_byte[0];
        res.cpu_window_extended   = xcpu || addon_bank != 8'd0;
        res.video_window_extended = xvid || addon_bank != 8'd0;
        res.port_bank_active      = ext;
        res.ext_bank              = ext ? ({1'b0, b & extmask} + offset) : 7'd0;
        res.addon_bank            = addon_bank;
    end

endmodule

// File: src/pbd_out.sv
// Result register with a one-entry skid stage for the output channel.
// Depends on pbd_pkg.
module pbd_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pbd_pkg::result_t load_res,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output pbd_pkg::result_t out_res
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    pbd_pkg::result_t out_res_reg;
    pbd_pkg::result_t skid_res_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || load;
            skid_valid_next = 1'b0;
        end
        else if (load)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_res_reg <= skid_valid_reg ? skid_res_reg : load_res;
        else if (load)
            skid_res_reg <= load_res;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");
    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !load)
        else $error("beat taken while skid stage full");
    a_bank_zero_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.port_bank_active |-> out_res_reg.ext_bank == 7'd0)
        else $error("bank number set without port banking");
`endif

endmodule
